/* hw/rtl/mre_pkg.sv */
package mre_pkg;

    localparam int MAX_LEN_DEF = 512;
    localparam int CHUNK_BYTES = 8;
    localparam int IDX_W       = 10;
    localparam int CNT_W       = $clog2(CHUNK_BYTES);

    localparam logic [7:0] MARK_ATTR_HI = 8'hFE;
    localparam logic [7:0] MARK_VAL_HI  = 8'hFD;
    localparam logic [7:0] MARK_SUB_HI  = 8'hFC;
    localparam logic [7:0] MARK_ATTR_LO = 8'h5E;
    localparam logic [7:0] MARK_VAL_LO  = 8'h5D;
    localparam logic [7:0] MARK_SUB_LO  = 8'h5C;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOLD_SETUP,
        ST_HOLD_RUN,
        ST_SEL_SETUP,
        ST_SEL_RUN,
        ST_EMIT_SETUP,
        ST_EMIT_RUN
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_SETUP_HOLD,
        CMD_SETUP,
        CMD_HOLD,
        CMD_SELECT,
        CMD_EMIT
    } t_op;

    typedef enum logic [1:0] {
        LVL_ATTR,
        LVL_VAL,
        LVL_SUB
    } t_level;

    typedef struct packed {
        logic   load;   // input transfer this cycle
        t_op    op;
        t_level level;
    } t_cmd;

    typedef struct packed {
        logic attr_in_nz;   // attribute index on the input ports is nonzero
        logic val_nz;
        logic sub_nz;
        logic done;         // current scan finishes this cycle
    } t_status;

endpackage

/* hw/rtl/mre_ram.sv */
module mre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/mre_ctrl.sv */
module mre_ctrl import mre_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_end_of_record,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state, n_state;
    t_level r_level, n_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_level <= LVL_ATTR;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_level      = r_level;
        o_cmd.load   = 1'b0;
        o_cmd.op     = CMD_NONE;
        o_cmd.level  = r_level;
        o_busy       = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_end_of_record) begin
                        n_level = LVL_ATTR;
                        n_state = i_status.attr_in_nz ? ST_HOLD_SETUP : ST_EMIT_SETUP;
                    end
                end
            end
            ST_HOLD_SETUP: begin
                o_cmd.op = CMD_SETUP_HOLD;
                n_state  = ST_HOLD_RUN;
            end
            ST_HOLD_RUN: begin
                o_cmd.op = CMD_HOLD;
                if (i_status.done) begin
                    n_state = ST_SEL_SETUP;
                end
            end
            ST_SEL_SETUP: begin
                o_cmd.op = CMD_SETUP;
                n_state  = ST_SEL_RUN;
            end
            ST_SEL_RUN: begin
                o_cmd.op = CMD_SELECT;
                if (i_status.done) begin
                    if (r_level == LVL_ATTR && i_status.val_nz) begin
                        n_level = LVL_VAL;
                        n_state = ST_HOLD_SETUP;
                    end else if (r_level == LVL_VAL && i_status.sub_nz) begin
                        n_level = LVL_SUB;
                        n_state = ST_HOLD_SETUP;
                    end else begin
                        n_state = ST_EMIT_SETUP;
                    end
                end
            end
            ST_EMIT_SETUP: begin
                o_cmd.op = CMD_SETUP;
                n_state  = ST_EMIT_RUN;
            end
            ST_EMIT_RUN: begin
                o_cmd.op = CMD_EMIT;
                if (i_status.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/mre_datapath.sv */
module mre_datapath import mre_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_end_of_record,
    input  logic [IDX_W-1:0]         i_attribute_index,
    input  logic [IDX_W-1:0]         i_value_index,
    input  logic [IDX_W-1:0]         i_subvalue_index,
    output logic                     o_chunk_valid,
    output logic [8*CHUNK_BYTES-1:0] o_chunk_data,
    output logic [3:0]               o_chunk_bytes,
    output logic                     o_chunk_last,
    output logic                     o_record_overflow
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int PW = $clog2(MAX_LEN + 2);
    localparam logic [PW-1:0] MAX_LEN_P = PW'(MAX_LEN);
    localparam logic [PW-1:0] ONE_P     = PW'(1);

    // loading state
    logic [PW-1:0] r_len, n_len;
    logic          r_ended, n_ended;
    logic          r_ovf, n_ovf;
    // scan state
    logic [PW-1:0]    r_rs, n_rs;
    logic [PW-1:0]    r_re, n_re;
    logic [PW-1:0]    r_pos, n_pos;
    logic [PW-1:0]    r_addr, n_addr;
    logic [PW-1:0]    r_fstart, n_fstart;
    logic [IDX_W-1:0] r_seen, n_seen;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_attr, n_attr;
    logic [IDX_W-1:0] r_val, n_val;
    logic [IDX_W-1:0] r_sub, n_sub;
    logic             r_ovf_out, n_ovf_out;
    // chunk assembly and output
    logic [8*CHUNK_BYTES-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_cv, n_cv;
    logic [8*CHUNK_BYTES-1:0] r_cdata, n_cdata;
    logic [3:0]               r_cbytes, n_cbytes;
    logic                     r_clast, n_clast;

    logic          we;
    logic [PW-1:0] raddr;
    logic [7:0]    q;
    logic [7:0]    mark_hi, mark_lo, mark;
    logic [IDX_W-1:0] cur_idx;
    logic          at_end;
    logic          done;

    mre_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_raddr (raddr[AW-1:0]),
        .o_rdata (q)
    );

    assign we = i_cmd.load && !r_ended && (i_data_byte != 8'd0) && (r_len < MAX_LEN_P);

    always_comb begin
        unique case (i_cmd.level)
            LVL_ATTR: begin
                mark_hi = MARK_ATTR_HI;
                mark_lo = MARK_ATTR_LO;
                cur_idx = r_attr;
            end
            LVL_VAL: begin
                mark_hi = MARK_VAL_HI;
                mark_lo = MARK_VAL_LO;
                cur_idx = r_val;
            end
            LVL_SUB: begin
                mark_hi = MARK_SUB_HI;
                mark_lo = MARK_SUB_LO;
                cur_idx = r_sub;
            end
            default: begin
                mark_hi = MARK_ATTR_HI;
                mark_lo = MARK_ATTR_LO;
                cur_idx = r_attr;
            end
        endcase
    end

    assign mark   = r_found ? mark_hi : mark_lo;
    assign at_end = (r_pos >= r_re);

    always_comb begin
        n_len     = r_len;
        n_ended   = r_ended;
        n_ovf     = r_ovf;
        n_rs      = r_rs;
        n_re      = r_re;
        n_pos     = r_pos + ONE_P;
        n_addr    = r_addr + ONE_P;
        n_fstart  = r_fstart;
        n_seen    = r_seen;
        n_found   = r_found;
        n_attr    = r_attr;
        n_val     = r_val;
        n_sub     = r_sub;
        n_ovf_out = r_ovf_out;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_cv      = 1'b0;
        n_cdata   = r_cdata;
        n_cbytes  = r_cbytes;
        n_clast   = r_clast;
        raddr     = r_addr;
        done      = 1'b0;

        if (i_cmd.load) begin
            if (!r_ended) begin
                if (i_data_byte == 8'd0) begin
                    n_ended = 1'b1;
                end else if (r_len < MAX_LEN_P) begin
                    n_len = r_len + ONE_P;
                end else begin
                    n_ovf = 1'b1;
                end
            end
            if (i_end_of_record) begin
                n_rs      = '0;
                n_re      = n_len;
                n_ovf_out = n_ovf;
                n_attr    = i_attribute_index;
                n_val     = i_value_index;
                n_sub     = i_subvalue_index;
                n_len     = '0;
                n_ended   = 1'b0;
                n_ovf     = 1'b0;
            end
        end

        unique case (i_cmd.op)
            CMD_NONE: begin
            end
            CMD_SETUP_HOLD, CMD_SETUP: begin
                raddr    = r_rs;
                n_pos    = r_rs;
                n_addr   = r_rs + ONE_P;
                n_fstart = r_rs;
                n_seen   = IDX_W'(1);
                n_acc    = '0;
                n_cnt    = '0;
                if (i_cmd.op == CMD_SETUP_HOLD) begin
                    n_found = 1'b0;
                end
            end
            CMD_HOLD: begin
                if (at_end) begin
                    done = 1'b1;
                end else if (q == mark_hi) begin
                    n_found = 1'b1;
                    done    = 1'b1;
                end
            end
            CMD_SELECT: begin
                if (at_end) begin
                    done = 1'b1;
                    if (r_seen < cur_idx) begin
                        n_rs = r_re;    // missing field
                    end else begin
                        n_rs = r_fstart;
                        n_re = r_pos;
                    end
                end else if (q == mark) begin
                    if (r_seen < cur_idx) begin
                        n_seen   = r_seen + IDX_W'(1);
                        n_fstart = r_pos + ONE_P;
                    end else begin
                        done = 1'b1;
                        n_rs = r_fstart;
                        n_re = r_pos;
                    end
                end
            end
            CMD_EMIT: begin
                if (at_end) begin
                    // empty text
                    done     = 1'b1;
                    n_cv     = 1'b1;
                    n_cdata  = '0;
                    n_cbytes = 4'd0;
                    n_clast  = 1'b1;
                end else begin
                    n_acc[8*r_cnt +: 8] = q;
                    n_cnt = r_cnt + CNT_W'(1);
                    if ((r_pos + ONE_P) >= r_re) begin
                        done     = 1'b1;
                        n_cv     = 1'b1;
                        n_cdata  = n_acc;
                        n_cbytes = 4'({1'b0, r_cnt} + 4'd1);
                        n_clast  = 1'b1;
                    end else if (r_cnt == CNT_W'(CHUNK_BYTES - 1)) begin
                        n_cv     = 1'b1;
                        n_cdata  = n_acc;
                        n_cbytes = 4'(CHUNK_BYTES);
                        n_clast  = 1'b0;
                        n_acc    = '0;
                        n_cnt    = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_ended <= 1'b0;
            r_ovf   <= 1'b0;
            r_cv    <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_ended <= n_ended;
            r_ovf   <= n_ovf;
            r_cv    <= n_cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rs      <= n_rs;
        r_re      <= n_re;
        r_pos     <= n_pos;
        r_addr    <= n_addr;
        r_fstart  <= n_fstart;
        r_seen    <= n_seen;
        r_found   <= n_found;
        r_attr    <= n_attr;
        r_val     <= n_val;
        r_sub     <= n_sub;
        r_ovf_out <= n_ovf_out;
        r_acc     <= n_acc;
        r_cnt     <= n_cnt;
        r_cdata   <= n_cdata;
        r_cbytes  <= n_cbytes;
        r_clast   <= n_clast;
    end

    assign o_status.attr_in_nz = (i_attribute_index != '0);
    assign o_status.val_nz     = (r_val != '0);
    assign o_status.sub_nz     = (r_sub != '0);
    assign o_status.done       = done;

    assign o_chunk_valid     = r_cv;
    assign o_chunk_data      = r_cdata;
    assign o_chunk_bytes     = r_cbytes;
    assign o_chunk_last      = r_clast;
    assign o_record_overflow = r_ovf_out;

endmodule

/* hw/rtl/multivalue_record_extract.sv */
// Channel   Ports                                          Transfer
// --------  ---------------------------------------------  ---------------------------
// input     i_data_byte, i_end_of_record, i_*_index        i_start && !o_busy
// result    o_chunk_data, o_chunk_bytes, o_chunk_last,     o_chunk_valid, one cycle
//           o_record_overflow
//
// Loading accepts one byte a cycle; o_busy stays low while bytes stream in.
// After the final byte, each requested level (attribute, value, subvalue) runs a
// mark search and a field select, each a setup step followed by a scan of the
// range; the emit scan also has a setup step and then moves one byte a cycle.
// Reset is synchronous, active low, and clears the loading and control state.
// The receiver cannot stall: each chunk is shown for exactly one cycle.
module multivalue_record_extract import mre_pkg::*; #(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_end_of_record,
    input  logic [IDX_W-1:0]         i_attribute_index,
    input  logic [IDX_W-1:0]         i_value_index,
    input  logic [IDX_W-1:0]         i_subvalue_index,
    output logic                     o_chunk_valid,
    output logic [8*CHUNK_BYTES-1:0] o_chunk_data,
    output logic [3:0]               o_chunk_bytes,
    output logic                     o_chunk_last,
    output logic                     o_record_overflow
);

    t_cmd    cmd;
    t_status status;

    // sequencer: picks mark search, field select and emit in turn
    mre_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_end_of_record (i_end_of_record),
        .i_status        (status),
        .o_cmd           (cmd),
        .o_busy          (o_busy)
    );

    // record store, range registers, scan pointer and chunk packer
    mre_datapath #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_data_byte       (i_data_byte),
        .i_end_of_record   (i_end_of_record),
        .i_attribute_index (i_attribute_index),
        .i_value_index     (i_value_index),
        .i_subvalue_index  (i_subvalue_index),
        .o_chunk_valid     (o_chunk_valid),
        .o_chunk_data      (o_chunk_data),
        .o_chunk_bytes     (o_chunk_bytes),
        .o_chunk_last      (o_chunk_last),
        .o_record_overflow (o_record_overflow)
    );

endmodule

/* tb/sv/multivalue_record_extract_test.sv */
module multivalue_record_extract_test;
    import mre_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Byte content styles for the random records
    localparam int STYLE_LOW   = 0;   // ASCII marks only
    localparam int STYLE_HIGH  = 1;   // high marks only
    localparam int STYLE_MIXED = 2;   // both; high marks win, low ones become plain text
    localparam int STYLE_NOISE = 3;   // any non-zero byte

    localparam int TAIL_CYCLES = 40;  // settle time after the last chunk

    typedef struct {
        logic [7:0]       data;
        logic             eor;
        logic [IDX_W-1:0] attr;
        logic [IDX_W-1:0] val;
        logic [IDX_W-1:0] sub;
        int unsigned      gap;        // idle cycles ahead of this transfer
    } t_byte_item;

    typedef struct packed {
        logic [8*CHUNK_BYTES-1:0] data;
        logic [3:0]               nbytes;
        logic                     last;
        logic                     ovf;
    } t_chunk;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_start = 1'b0;
    logic [7:0]               i_data_byte = '0;
    logic                     i_end_of_record = 1'b0;
    logic [IDX_W-1:0]         i_attribute_index = '0;
    logic [IDX_W-1:0]         i_value_index = '0;
    logic [IDX_W-1:0]         i_subvalue_index = '0;
    logic                     o_busy;
    logic                     o_chunk_valid;
    logic [8*CHUNK_BYTES-1:0] o_chunk_data;
    logic [3:0]               o_chunk_bytes;
    logic                     o_chunk_last;
    logic                     o_record_overflow;

    multivalue_record_extract dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (i_start),
        .o_busy            (o_busy),
        .i_data_byte       (i_data_byte),
        .i_end_of_record   (i_end_of_record),
        .i_attribute_index (i_attribute_index),
        .i_value_index     (i_value_index),
        .i_subvalue_index  (i_subvalue_index),
        .o_chunk_valid     (o_chunk_valid),
        .o_chunk_data      (o_chunk_data),
        .o_chunk_bytes     (o_chunk_bytes),
        .o_chunk_last      (o_chunk_last),
        .o_record_overflow (o_record_overflow)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: record bytes, length, end-of-text and overflow
    // flags, plus the chunks still owed on the result side.
    // ------------------------------------------------------------------
    logic [7:0]  rec_bytes [0:MAX_LEN_DEF-1];
    int unsigned rec_len;
    bit          text_done;
    bit          rec_ovf;
    t_chunk      chunk_fifo [$];

    t_byte_item  byte_queue [$];
    t_byte_item  cur_item;
    int unsigned sent_cnt;
    int unsigned taken_cnt;
    int unsigned idle_cycles;

    int unsigned error_count;
    int unsigned records_done;
    int unsigned ovf_records;
    int unsigned chunks_checked;

    // Stimulus shaping
    bit          burst_mode;
    int          mark_style;
    int unsigned rand_items;

    function automatic bit range_has_mark(logic [7:0] mark, int unsigned lo, int unsigned hi);
        for (int unsigned p = lo; p < hi; p++)
            if (rec_bytes[p] == mark)
                return 1'b1;
        return 1'b0;
    endfunction

    // Shrink [lo, hi) to field number idx (1-based) split on mark.
    // Running off the end leaves an empty range.
    function automatic void narrow_to_field(logic [7:0] mark, int unsigned idx,
                                            inout int unsigned lo, inout int unsigned hi);
        int unsigned seen;
        int unsigned pos;
        int unsigned first;
        seen = 1;
        if (lo >= hi) begin
            hi = lo;
            return;
        end
        pos = lo;
        while (seen < idx) begin
            while (pos < hi && rec_bytes[pos] != mark)
                pos++;
            if (pos >= hi) begin
                lo = hi;
                return;
            end
            pos++;
            seen++;
        end
        first = pos;
        while (pos < hi && rec_bytes[pos] != mark)
            pos++;
        lo = first;
        hi = pos;
    endfunction

    // Apply one accepted byte; on the final byte, queue the chunks the
    // selected field should produce and clear the loading state.
    function automatic void take_record_byte(logic [7:0] b, logic eor, logic [IDX_W-1:0] attr,
                                             logic [IDX_W-1:0] val, logic [IDX_W-1:0] sub);
        int unsigned lo;
        int unsigned hi;
        int unsigned pos;
        int unsigned n;
        logic [7:0]  mark;
        t_chunk      c;
        if (!text_done) begin
            if (b == 8'h00)
                text_done = 1'b1;
            else if (rec_len < MAX_LEN_DEF) begin
                rec_bytes[rec_len] = b;
                rec_len++;
            end else
                rec_ovf = 1'b1;
        end
        if (!eor)
            return;

        lo = 0;
        hi = rec_len;
        if (attr != 0) begin
            mark = range_has_mark(MARK_ATTR_HI, lo, hi) ? MARK_ATTR_HI : MARK_ATTR_LO;
            narrow_to_field(mark, attr, lo, hi);
            if (val != 0) begin
                mark = range_has_mark(MARK_VAL_HI, lo, hi) ? MARK_VAL_HI : MARK_VAL_LO;
                narrow_to_field(mark, val, lo, hi);
                if (sub != 0) begin
                    mark = range_has_mark(MARK_SUB_HI, lo, hi) ? MARK_SUB_HI : MARK_SUB_LO;
                    narrow_to_field(mark, sub, lo, hi);
                end
            end
        end

        // Empty text still yields one chunk, zero bytes, last set
        pos = lo;
        do begin
            c = '0;
            n = 0;
            while (n < CHUNK_BYTES && pos < hi) begin
                c.data[8*n +: 8] = rec_bytes[pos];
                n++;
                pos++;
            end
            c.nbytes = 4'(n);
            c.last   = (pos >= hi);
            c.ovf    = rec_ovf;
            chunk_fifo.push_back(c);
        end while (pos < hi);

        records_done++;
        if (rec_ovf)
            ovf_records++;
        rec_len   = 0;
        text_done = 1'b0;
        rec_ovf   = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers the head of byte_queue after its idle gap and holds
    // it until the block takes the transfer (start high, busy low).
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && sent_cnt != taken_cnt) begin
            // offered, not yet taken: hold everything
        end else if (byte_queue.size() == 0) begin
            i_start <= 1'b0;
        end else if (idle_cycles < byte_queue[0].gap) begin
            i_start <= 1'b0;
            idle_cycles++;
        end else begin
            cur_item = byte_queue.pop_front();
            i_data_byte       <= cur_item.data;
            i_end_of_record   <= cur_item.eor;
            i_attribute_index <= cur_item.attr;
            i_value_index     <= cur_item.val;
            i_subvalue_index  <= cur_item.sub;
            i_start           <= 1'b1;
            idle_cycles = 0;
            sent_cnt++;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every input transfer, then checks any chunk on
    // the result ports against the oldest owed chunk. A transfer and a
    // chunk in the same cycle are independent, so the order is harmless.
    // ------------------------------------------------------------------
    t_chunk want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                taken_cnt++;
                take_record_byte(i_data_byte, i_end_of_record, i_attribute_index,
                                 i_value_index, i_subvalue_index);
            end
            if (o_chunk_valid) begin
                if (chunk_fifo.size() == 0) begin
                    $error("chunk arrived with none outstanding (data %h bytes %0d)",
                           o_chunk_data, o_chunk_bytes);
                    error_count++;
                end else begin
                    want = chunk_fifo.pop_front();
                    chunks_checked++;
                    if (o_chunk_data !== want.data) begin
                        $error("chunk_data: expected %h, got %h", want.data, o_chunk_data);
                        error_count++;
                    end
                    if (o_chunk_bytes !== want.nbytes) begin
                        $error("chunk_bytes: expected %0d, got %0d", want.nbytes, o_chunk_bytes);
                        error_count++;
                    end
                    if (o_chunk_last !== want.last) begin
                        $error("chunk_last: expected %b, got %b", want.last, o_chunk_last);
                        error_count++;
                    end
                    if (o_record_overflow !== want.ovf) begin
                        $error("record_overflow: expected %b, got %b", want.ovf,
                               o_record_overflow);
                        error_count++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [IDX_W-1:0] rand_index();
        // mostly small so fields are actually hit; now and then anything
        if ($urandom_range(0, 9) == 0)
            return IDX_W'($urandom_range(0, 1023));
        return IDX_W'($urandom_range(0, 4));
    endfunction

    function automatic logic [7:0] text_byte();
        int unsigned r;
        bit          hi;
        r  = $urandom_range(0, 99);
        hi = (mark_style == STYLE_HIGH) || (mark_style == STYLE_MIXED && $urandom_range(0, 1));
        if (mark_style == STYLE_NOISE || r < 5)
            return 8'($urandom_range(1, 255));
        if (r < 20)
            return hi ? MARK_ATTR_HI : MARK_ATTR_LO;
        if (r < 33)
            return hi ? MARK_VAL_HI : MARK_VAL_LO;
        if (r < 45)
            return hi ? MARK_SUB_HI : MARK_SUB_LO;
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    task automatic queue_byte(logic [7:0] b, logic eor, logic [IDX_W-1:0] attr,
                              logic [IDX_W-1:0] val, logic [IDX_W-1:0] sub);
        t_byte_item it;
        it.data = b;
        it.eor  = eor;
        it.attr = attr;
        it.val  = val;
        it.sub  = sub;
        it.gap  = burst_mode ? 0 : $urandom_range(0, 9);
        byte_queue.push_back(it);
    endtask

    // Non-final byte: indices are don't-care, so toggle them freely
    task automatic put_byte(logic [7:0] b);
        queue_byte(b, 1'b0, IDX_W'($urandom_range(0, 1023)), IDX_W'($urandom_range(0, 1023)),
                   IDX_W'($urandom_range(0, 1023)));
    endtask

    task automatic put_final(logic [7:0] b, logic [IDX_W-1:0] attr, logic [IDX_W-1:0] val,
                             logic [IDX_W-1:0] sub);
        queue_byte(b, 1'b1, attr, val, sub);
    endtask

    // Long record filling the store; with spill set it runs past capacity,
    // then ends the text and trails two bytes that must be ignored.
    task automatic long_record(int unsigned n_text, bit spill);
        for (int unsigned k = 1; k < n_text; k++)
            put_byte(text_byte());
        if (spill) begin
            put_byte(text_byte());
            put_byte(8'h00);
            put_byte(8'($urandom_range(0, 255)));
            put_final(8'($urandom_range(0, 255)), rand_index(), rand_index(), rand_index());
        end else
            put_final(text_byte(), rand_index(), rand_index(), rand_index());
    endtask

    // ------------------------------------------------------------------
    // Stimulus, end of test
    // ------------------------------------------------------------------
    initial begin
        int unsigned len;
        int unsigned rec;

        burst_mode = 1'b1;

        // Empty record: zero byte alone; any field of empty text is empty
        put_final(8'h00, 10'd1, 10'd1, 10'd1);

        // ASCII marks, deepest level: "ab^c]d\e" -> attr 2, value 2, sub 2 = "e"
        burst_mode = 1'b0;
        put_byte("a");
        put_byte("b");
        put_byte(MARK_ATTR_LO);
        put_byte("c");
        put_byte(MARK_VAL_LO);
        put_byte("d");
        put_byte(MARK_SUB_LO);
        put_byte("e");
        put_final(8'h00, 10'd2, 10'd2, 10'd2);

        // High marks take over; the ASCII marks turn into plain text.
        // Final byte is non-zero and loaded like any other.
        put_byte(MARK_ATTR_LO);
        put_byte(MARK_ATTR_HI);
        put_byte("a");
        put_byte(MARK_VAL_HI);
        put_byte(MARK_VAL_LO);
        put_byte(MARK_SUB_HI);
        put_final("b", 10'd2, 10'd2, 10'd2);

        // Missing field at maximum indices
        burst_mode = 1'b1;
        put_byte("q");
        put_byte(MARK_ATTR_LO);
        put_final("r", 10'd1023, 10'd1023, 10'd1023);

        // Whole record; bytes after the ending zero are ignored
        put_byte("h");
        put_byte("i");
        put_byte(8'h00);
        put_byte(8'hFF);
        put_final(8'h80, 10'd0, 10'd1023, 10'd1023);

        // Random records: mostly short and mark-rich, now and then longer,
        // and one that fills the store and runs past it.
        rand_items = 0;
        rec = 0;
        while (rand_items < 480) begin
            burst_mode = ($urandom_range(0, 2) == 0);
            mark_style = $urandom_range(STYLE_LOW, STYLE_NOISE);
            if (rec == 16) begin
                long_record(MAX_LEN_DEF + 2, 1'b1);
                rand_items += MAX_LEN_DEF + 5;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(0, 12);
                for (int unsigned k = 0; k < len; k++)
                    put_byte(($urandom_range(0, 29) == 0) ? 8'h00 : text_byte());
                put_final(($urandom_range(0, 2) == 0) ? 8'h00 : text_byte(),
                          rand_index(), rand_index(), rand_index());
                rand_items += len + 1;
            end
            rec++;
        end

        // Single reset, released once before the run
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything sent and taken, every owed chunk seen
        @(negedge i_clk);
        while (byte_queue.size() != 0 || sent_cnt != taken_cnt || chunk_fifo.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run covered %0d byte transfers and %0d records (%0d overflowed),",
                 taken_cnt, records_done, ovf_records);
        $display("with %0d result chunks checked field by field.", chunks_checked);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Timeout: transfers sent %0d, taken %0d, chunks outstanding %0d",
                 sent_cnt, taken_cnt, chunk_fifo.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/mre_pkg.sv
hw/rtl/mre_ram.sv
hw/rtl/mre_ctrl.sv
hw/rtl/mre_datapath.sv
hw/rtl/multivalue_record_extract.sv
tb/sv/multivalue_record_extract_test.sv
